### hdl/ddfc_pkg.sv
// Package with shared constants and stage payload types for the DSP float converter.
`default_nettype none
package ddfc_pkg;
  localparam int MANT_BITS = 23;
  localparam int EXP_BITS  = 8;
  localparam int EXP_BIAS  = 128;
  localparam int DBL_FRAC  = 52;
  localparam int DBL_BIAS  = 1023;
  localparam int DROP      = DBL_FRAC - MANT_BITS;

  // Payload after the first stage: operand unpacked, rounding done.
  typedef struct packed {
    logic        mode;
    logic        neg;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic        is_sub;
    logic signed [12:0] exp;
    logic [24:0] v;
    logic [31:0] w;
  } s1_t;

  // Payload after the second stage: normalization and sign handling done.
  typedef struct packed {
    logic        mode;
    logic        neg;
    logic        kill;
    logic        flush;
    logic        sat;
    logic signed [12:0] exp;
    logic [24:0] v;
    logic [31:0] w;
  } s2_t;
endpackage
`default_nettype wire

### hdl/ddfc_round.sv
// First stage: unpacks the double and rounds its significand to 24 bits.
`default_nettype none
module ddfc_round (
  input  wire logic        mode,
  input  wire logic [63:0] operand,
  output ddfc_pkg::s1_t    s1
);
  logic [10:0] e;
  logic [51:0] f;
  logic [23:0] top;
  logic [24:0] v;
  always_comb begin
    e   = operand[62:52];
    f   = operand[51:0];
    top = {1'b1, f[51:29]};
    v   = {1'b0, top} + {24'd0, f[28]};
    s1.mode    = mode;
    s1.neg     = operand[63];
    s1.is_nan  = (e == 11'h7FF) && (f != 52'd0);
    s1.is_inf  = (e == 11'h7FF) && (f == 52'd0);
    s1.is_zero = (e == 11'd0) && (f == 52'd0);
    s1.is_sub  = (e == 11'd0) && (f != 52'd0);
    s1.exp     = $signed({2'b00, e}) - 13'sd1023;
    s1.v       = v;
    s1.w       = operand[31:0];
  end
endmodule
`default_nettype wire

### hdl/ddfc_norm.sv
// Second stage: renormalizes, negates and classifies the exponent range.
`default_nettype none
module ddfc_norm (
  input  wire ddfc_pkg::s1_t s1,
  output ddfc_pkg::s2_t s2
);
  logic signed [12:0] exp;
  logic [24:0] v;
  always_comb begin
    exp = s1.exp;
    v   = s1.v;
    if (v[24]) begin
      v   = v >> 1;
      exp = exp + 13'sd1;
    end
    if (s1.neg) begin
      v = (~v + 25'd1) & 25'h0FFFFFF;
      if (v[23]) begin
        v   = {v[23:0], 1'b0};
        exp = exp - 13'sd1;
      end
    end
    s2.mode  = s1.mode;
    s2.neg   = s1.neg;
    s2.w     = s1.w;
    s2.v     = v;
    s2.exp   = exp;
    s2.kill  = s1.is_nan || s1.is_zero;
    s2.flush = s1.is_sub || (!s1.is_nan && !s1.is_inf && !s1.is_zero && exp < -13'sd127);
    s2.sat   = s1.is_inf || (!s1.is_nan && !s1.is_zero && !s1.is_sub && exp > 13'sd127);
  end
endmodule
`default_nettype wire

### hdl/ddfc_pack.sv
// Third stage: packs the DSP word, or expands a DSP word into double bits.
`default_nettype none
module ddfc_pack (
  input  wire ddfc_pkg::s2_t s2,
  output logic [63:0]   result,
  output logic          flushed,
  output logic          saturated
);
  logic [22:0] frac;
  logic [7:0]  ecode;
  logic [24:0] mag;
  logic [10:0] dexp;
  always_comb begin
    result = 64'd0; flushed = 1'b0; saturated = 1'b0;
    frac = 23'd0; ecode = 8'd0; mag = 25'd0; dexp = 11'd0;
    if (s2.mode) begin
      ecode = s2.w[7:0];
      frac  = s2.w[30:8];
      if (ecode != 8'd0) begin
        dexp = 11'd895 + {3'd0, ecode};
        if (s2.w[31]) mag = 25'h1000000 - {2'd0, frac};
        else          mag = 25'h0800000 + {2'd0, frac};
        if (mag[24]) begin
          mag  = mag >> 1;
          dexp = dexp + 11'd1;
        end
        result = {s2.w[31], dexp, mag[22:0], 29'd0};
      end
    end else if (s2.kill) begin
      result = 64'd0;
    end else if (s2.flush) begin
      flushed = 1'b1;
    end else begin
      if (s2.sat) begin
        saturated = 1'b1;
        frac  = s2.neg ? 23'd0 : 23'h7FFFFF;
        ecode = 8'd255;
      end else begin
        frac  = s2.v[22:0];
        ecode = 8'(s2.exp + 13'sd128);
      end
      result = {32'd0, s2.neg, frac, ecode};
    end
  end
endmodule
`default_nettype wire

### hdl/double_dsp_float_converter_core.sv
// Top level of the double / DSP float converter: a three-stage stallable pipeline.
//
// Input channel: in_valid, in_stall, mode, operand. A word is taken at a rising
// edge with in_valid high and in_stall low. Mode 0 turns IEEE double bits into a
// 32-bit DSP float word (zero-extended), mode 1 turns the DSP word in the low 32
// bits of operand into double bits, exactly.
// Output channel: out_valid, out_stall, result, flushed, saturated.
// An accepted word passes through the s1, s2 and output registers, and
// out_valid rises when it reaches the output register. One word enters every
// cycle while in_stall is low; the three register stages are rounding,
// normalization, and packing, each registered with a valid bit of its own.
// When the receiver raises out_stall, a stage holds its word only where the
// stage after it is full and held too, so bubbles close up; in_stall rises
// only when the whole pipe is full and the output is stalled.
// Synchronous reset clears all valid bits; payload registers are not reset.
`default_nettype none
module double_dsp_float_converter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [63:0] operand,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      result,
  output logic             flushed,
  output logic             saturated
);
  ddfc_pkg::s1_t s1_d, s1;
  ddfc_pkg::s2_t s2_d, s2;
  logic [63:0]   r_d;
  logic          f_d, sa_d;
  logic          v1, v2;
  logic          adv1, adv2, adv3;

  ddfc_round u_round (.mode(mode), .operand(operand), .s1(s1_d));
  ddfc_norm  u_norm  (.s1(s1), .s2(s2_d));
  ddfc_pack  u_pack  (.s2(s2), .result(r_d), .flushed(f_d), .saturated(sa_d));

  // Each stage loads when it is empty or the stage after it is moving.
  assign adv3     = !out_valid || !out_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) out_valid <= v2;
    end
    if (adv1) s1 <= s1_d;
    if (adv2) s2 <= s2_d;
    if (adv3) begin
      result <= r_d; flushed <= f_d; saturated <= sa_d;
    end
  end
endmodule
`default_nettype wire

### hdl/ddfc_checker.sv
// Port-level checker for the converter, bound to the top level.
`default_nettype none
module ddfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] result,
  input wire logic        flushed,
  input wire logic        saturated
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result)) else $error("held word changed");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(flushed && saturated)) else $error("both flags set");
  a_flush: assert property (@(posedge clk) disable iff (rst)
    out_valid && flushed |-> result == 64'd0) else $error("flush with nonzero word");
  a_nostall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("input stalled while output is empty");
endmodule

bind double_dsp_float_converter_core ddfc_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .result(result),
  .flushed(flushed), .saturated(saturated));
`default_nettype wire
